// ===== sv/expression_token_lexer_assert.svh =====
// assertion macros for the token lexer
`ifndef EXPRESSION_TOKEN_LEXER_ASSERT_SVH
`define EXPRESSION_TOKEN_LEXER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define ETL_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define ETL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ETL_ASSERT_ALWAYS(lbl, expr, msg)

`define ETL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/etl_pkg.sv =====
`timescale 1ns / 1ps

package etl_pkg;

	localparam int MAX_TOKEN_LENGTH_DEF = 255;
	localparam int POSITION_BITS_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;

	// token queue, depth a power of two
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam logic SRC_CHAR = 1'b0;
	localparam logic SRC_END = 1'b1;

	localparam logic [3:0] KIND_NUMBER = 4'd0;
	localparam logic [3:0] KIND_IDENT = 4'd1;
	localparam logic [3:0] KIND_ASSIGN = 4'd2;
	localparam logic [3:0] KIND_ADD = 4'd3;
	localparam logic [3:0] KIND_SUB = 4'd4;
	localparam logic [3:0] KIND_MUL = 4'd5;
	localparam logic [3:0] KIND_DIV = 4'd6;
	localparam logic [3:0] KIND_SEMI = 4'd7;
	localparam logic [3:0] KIND_LPAR = 4'd8;
	localparam logic [3:0] KIND_RPAR = 4'd9;
	localparam logic [3:0] KIND_INVALID = 4'd10;
	localparam logic [3:0] KIND_END = 4'd11;

	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_EQ = 8'h3d;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_LPAR = 8'h28;
	localparam logic [7:0] CH_RPAR = 8'h29;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7a;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UZ = 8'h5a;
	localparam logic [7:0] CH_US = 8'h5f;

	typedef struct packed {
		logic mode;
		logic [7:0] char_code;
	} src_word_t;

	typedef struct packed {
		logic [3:0] token_kind;
		logic [31:0] token_offset;
		logic [7:0] token_length;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic last_of_run;
	} tok_word_t;

	typedef struct packed {
		logic push0;
		logic push1;
		tok_word_t tok0;
		tok_word_t tok1;
	} tok_push_t;

	typedef struct packed {
		logic room;
		logic [Q_PTR_W:0] level;
	} q_stat_t;

	// {hit, kind} for single-character operators
	function automatic logic [4:0] op_kind(input logic [7:0] c);
		logic [4:0] r;
		case (c)
			CH_EQ: r = {1'b1, KIND_ASSIGN};
			CH_PLUS: r = {1'b1, KIND_ADD};
			CH_MINUS: r = {1'b1, KIND_SUB};
			CH_STAR: r = {1'b1, KIND_MUL};
			CH_SLASH: r = {1'b1, KIND_DIV};
			CH_SEMI: r = {1'b1, KIND_SEMI};
			CH_LPAR: r = {1'b1, KIND_LPAR};
			CH_RPAR: r = {1'b1, KIND_RPAR};
			default: r = {1'b0, KIND_INVALID};
		endcase
		return r;
	endfunction

endpackage

// ===== sv/etl_scan.sv =====
`timescale 1ns / 1ps

module etl_scan #(
	parameter int MAX_TOKEN_LENGTH = etl_pkg::MAX_TOKEN_LENGTH_DEF,
	parameter int POSITION_BITS = etl_pkg::POSITION_BITS_DEF,
	parameter int OFFSET_BITS = etl_pkg::OFFSET_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic src_valid,
	output logic src_stall,
	input etl_pkg::src_word_t src_data,
	input logic room,
	output etl_pkg::tok_push_t push
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_NUM = 2'd1;
	localparam logic [1:0] ST_ID = 2'd2;
	localparam logic [1:0] ST_STOP = 2'd3;

	localparam int LEN_LIM = (MAX_TOKEN_LENGTH < 255) ? MAX_TOKEN_LENGTH : 255;
	localparam logic [7:0] LEN_MAX = 8'(LEN_LIM);
	localparam logic [OFFSET_BITS-1:0] OMAX = '1;
	localparam logic [POSITION_BITS-1:0] PMAX = '1;

	function automatic logic [31:0] off32(input logic [OFFSET_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[31:0];
	endfunction

	function automatic logic [15:0] pos16(input logic [POSITION_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[15:0];
	endfunction

	logic vld_s1;
	etl_pkg::src_word_t word_s1;

	logic [1:0] mode_q, mode_n;
	logic [OFFSET_BITS-1:0] byte_q, byte_n;
	logic [POSITION_BITS-1:0] line_q, line_n, col_q, col_n, col_sat;
	logic [OFFSET_BITS-1:0] pend_off_q, pend_off_n;
	logic [POSITION_BITS-1:0] pend_line_q, pend_line_n, pend_col_q, pend_col_n;
	logic [7:0] pend_len_q, pend_len_n;

	logic [7:0] c;
	logic is_dig, is_let, is_sp, is_nl, is_op, is_end, stopped, in_run, extend;
	logic emit_run, emit_cur, fire;
	logic [4:0] op;
	etl_pkg::tok_word_t run_tok, cur_tok;

	assign fire = vld_s1 && room;
	assign src_stall = vld_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!src_stall) begin
			vld_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			word_s1 <= src_data;
		end
	end

	always_comb begin
		c = word_s1.char_code;
		is_dig = c inside {[etl_pkg::CH_0:etl_pkg::CH_9]};
		is_let = c inside {[etl_pkg::CH_LA:etl_pkg::CH_LZ], [etl_pkg::CH_UA:etl_pkg::CH_UZ],
			etl_pkg::CH_US};
		is_sp = c inside {etl_pkg::CH_SP, etl_pkg::CH_TAB, etl_pkg::CH_CR, etl_pkg::CH_LF};
		is_nl = c inside {etl_pkg::CH_CR, etl_pkg::CH_LF};
		op = etl_pkg::op_kind(c);
		is_op = op[4];
		is_end = word_s1.mode == etl_pkg::SRC_END;
		stopped = mode_q == ST_STOP;
		in_run = mode_q == ST_NUM || mode_q == ST_ID;
		extend = (mode_q == ST_NUM && is_dig) || (mode_q == ST_ID && (is_dig || is_let));

		col_sat = (col_q == PMAX) ? col_q : col_q + 1'b1;
		byte_n = (byte_q == OMAX) ? byte_q : byte_q + 1'b1;
		if (is_nl) begin
			line_n = (line_q == PMAX) ? line_q : line_q + 1'b1;
			col_n = POSITION_BITS'(1);
		end else begin
			line_n = line_q;
			col_n = col_sat;
		end

		run_tok.token_kind = (mode_q == ST_NUM) ? etl_pkg::KIND_NUMBER : etl_pkg::KIND_IDENT;
		run_tok.token_offset = off32(pend_off_q);
		run_tok.token_length = pend_len_q;
		run_tok.start_line = pos16(pend_line_q);
		run_tok.start_column = pos16(pend_col_q);
		run_tok.last_of_run = 1'b0;

		if (is_end) begin
			cur_tok.token_kind = etl_pkg::KIND_END;
			cur_tok.token_offset = off32(byte_q);
			cur_tok.token_length = 8'd0;
			cur_tok.start_line = pos16(line_q);
			cur_tok.start_column = pos16(col_sat);
		end else begin
			cur_tok.token_kind = is_op ? op[3:0] : etl_pkg::KIND_INVALID;
			cur_tok.token_offset = off32(byte_q);
			cur_tok.token_length = 8'd1;
			cur_tok.start_line = pos16(line_n);
			cur_tok.start_column = pos16(col_n);
		end
		cur_tok.last_of_run = 1'b1;

		emit_run = !stopped && in_run && (is_end || !extend);
		emit_cur = !stopped && (is_end || (!extend && !is_sp && !is_dig && !is_let));

		push.push0 = fire && (emit_run || emit_cur);
		push.push1 = fire && emit_run && emit_cur;
		push.tok0 = emit_run ? run_tok : cur_tok;
		push.tok0.last_of_run = !(emit_run && emit_cur);
		push.tok1 = cur_tok;
	end

	always_comb begin
		mode_n = mode_q;
		pend_off_n = pend_off_q;
		pend_line_n = pend_line_q;
		pend_col_n = pend_col_q;
		pend_len_n = pend_len_q;
		if (is_end) begin
			mode_n = ST_STOP;
		end else if (extend) begin
			pend_len_n = (pend_len_q >= LEN_MAX) ? LEN_MAX : pend_len_q + 1'b1;
		end else if (is_dig || is_let) begin
			mode_n = is_dig ? ST_NUM : ST_ID;
			pend_off_n = byte_q;
			pend_line_n = line_n;
			pend_col_n = col_n;
			pend_len_n = 8'd1;
		end else if (is_sp || is_op) begin
			mode_n = ST_IDLE;
		end else begin
			mode_n = ST_STOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ST_IDLE;
			byte_q <= '0;
			line_q <= POSITION_BITS'(1);
			col_q <= '0;
			pend_off_q <= '0;
			pend_line_q <= '0;
			pend_col_q <= '0;
			pend_len_q <= '0;
		end else if (fire && !stopped) begin
			mode_q <= mode_n;
			pend_off_q <= pend_off_n;
			pend_line_q <= pend_line_n;
			pend_col_q <= pend_col_n;
			pend_len_q <= pend_len_n;
			if (!is_end) begin
				byte_q <= byte_n;
				line_q <= line_n;
				col_q <= col_n;
			end
		end
	end

endmodule

// ===== sv/etl_queue.sv =====
`timescale 1ns / 1ps

module etl_queue (
	input logic clk,
	input logic arst_n,
	input etl_pkg::tok_push_t push,
	output logic tok_valid,
	input logic tok_stall,
	output etl_pkg::tok_word_t tok_data,
	output etl_pkg::q_stat_t stat
);

	localparam int PW = etl_pkg::Q_PTR_W;
	localparam int CW = etl_pkg::Q_PTR_W + 1;

	etl_pkg::tok_word_t mem [etl_pkg::Q_DEPTH];
	logic [PW-1:0] wr_q, rd_q, wr_n;
	logic [CW-1:0] cnt_q;
	logic pop;

	assign pop = (cnt_q != '0) && !tok_stall;
	assign tok_valid = cnt_q != '0;
	assign tok_data = mem[rd_q];
	assign stat.room = cnt_q <= CW'(etl_pkg::Q_DEPTH - 2);
	assign stat.level = cnt_q;

	always_comb begin
		if (push.push1) begin
			wr_n = wr_q + PW'(2);
		end else if (push.push0) begin
			wr_n = wr_q + PW'(1);
		end else begin
			wr_n = wr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_n;
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push.push0) + CW'(push.push1) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem[wr_q] <= push.tok0;
		end
		if (push.push1) begin
			mem[wr_q + PW'(1)] <= push.tok1;
		end
	end

endmodule

// ===== sv/expression_token_lexer.sv =====
// channel | valid     | stall     | word
// source  | src_valid | src_stall | src_data: mode, char_code
// tokens  | tok_valid | tok_stall | tok_data: kind, offset, length, line, column, last
//
// one source word per cycle unless stalled; tokens pass the input register and queue
// a word's two tokens are queued at once and read out in turn by the single read port
// src_stall rises when a word sits in the input register and the token queue has
// fewer than two free entries
// reset clears the scan state, counters and queue at once; no clearing pass
`timescale 1ns / 1ps
`include "expression_token_lexer_assert.svh"

module expression_token_lexer #(
	parameter int MAX_TOKEN_LENGTH = etl_pkg::MAX_TOKEN_LENGTH_DEF,
	parameter int POSITION_BITS = etl_pkg::POSITION_BITS_DEF,
	parameter int OFFSET_BITS = etl_pkg::OFFSET_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic src_valid,
	output logic src_stall,
	input etl_pkg::src_word_t src_data,
	output logic tok_valid,
	input logic tok_stall,
	output etl_pkg::tok_word_t tok_data
);

	etl_pkg::tok_push_t push;
	etl_pkg::q_stat_t stat;
	logic [3:0] last_kind;
	logic stop_push;
	logic level_ok;
	logic pair_ok;

	etl_scan #(
		.MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH),
		.POSITION_BITS(POSITION_BITS),
		.OFFSET_BITS(OFFSET_BITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data(src_data),
		.room(stat.room),
		.push(push)
	);

	etl_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_data(tok_data),
		.stat(stat)
	);

	// kind of the final token pushed this cycle
	assign last_kind = push.push1 ? push.tok1.token_kind : push.tok0.token_kind;
	assign stop_push = push.push0 &&
		(last_kind == etl_pkg::KIND_END || last_kind == etl_pkg::KIND_INVALID);
	assign level_ok = stat.level <= (etl_pkg::Q_PTR_W + 1)'(etl_pkg::Q_DEPTH);
	assign pair_ok = !push.push1 || (push.push0 && !push.tok0.last_of_run);

	`ETL_ASSERT_ALWAYS(a_level, level_ok, "token queue overflow")
	`ETL_ASSERT_ALWAYS(a_room, !push.push0 || stat.room, "token pushed without queue room")
	`ETL_ASSERT_ALWAYS(a_pair, pair_ok, "second token without a first")
	`ETL_ASSERT_NEXT(a_stop, stop_push, !push.push0, "token pushed after end or invalid")

endmodule

// ===== dv/expression_token_lexer_checker.sv =====
`timescale 1ns / 1ps

module expression_token_lexer_checker (
	input logic clk,
	input logic arst_n,
	input logic src_valid,
	input logic src_stall,
	input etl_pkg::src_word_t src_data,
	input logic tok_valid,
	input logic tok_stall,
	input etl_pkg::tok_word_t tok_data,
	output int errors,
	output int outstanding,
	output int tokens_checked
);
	import etl_pkg::*;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_IDENT, SCAN_STOPPED} scan_t;

	localparam logic [7:0] RUN_LEN_CAP = 8'((MAX_TOKEN_LENGTH_DEF < 255) ?
		MAX_TOKEN_LENGTH_DEF : 255);

	scan_t scan;
	logic [31:0] bytes_seen;
	logic [15:0] line_no;
	logic [15:0] col_no;
	logic [31:0] run_offset;
	logic [15:0] run_line;
	logic [15:0] run_col;
	logic [7:0] run_len;

	tok_word_t due_tokens[$];
	tok_word_t word_tokens[$];
	tok_word_t want;
	int mismatch_count = 0;
	int due_count = 0;
	int checked_count = 0;

	assign errors = mismatch_count;
	assign outstanding = due_count;
	assign tokens_checked = checked_count;

	function automatic logic [15:0] bump_position(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic is_digit_byte(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic logic is_word_byte(input logic [7:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_US;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic [3:0] single_kind(input logic [7:0] c);
		logic [3:0] k;
		case (c)
			CH_EQ: k = KIND_ASSIGN;
			CH_PLUS: k = KIND_ADD;
			CH_MINUS: k = KIND_SUB;
			CH_STAR: k = KIND_MUL;
			CH_SLASH: k = KIND_DIV;
			CH_SEMI: k = KIND_SEMI;
			CH_LPAR: k = KIND_LPAR;
			CH_RPAR: k = KIND_RPAR;
			default: k = KIND_INVALID;
		endcase
		return k;
	endfunction

	function automatic tok_word_t make_token(input logic [3:0] kind, input logic [31:0] off,
		input logic [7:0] len, input logic [15:0] line, input logic [15:0] col);
		tok_word_t t;
		t.token_kind = kind;
		t.token_offset = off;
		t.token_length = len;
		t.start_line = line;
		t.start_column = col;
		t.last_of_run = 1'b0;
		return t;
	endfunction

	task automatic add_token(input tok_word_t t);
		word_tokens = {word_tokens, t};
	endtask

	task automatic flush_run();
		if (scan == SCAN_NUMBER || scan == SCAN_IDENT) begin
			add_token(make_token(scan == SCAN_NUMBER ? KIND_NUMBER : KIND_IDENT,
				run_offset, run_len, run_line, run_col));
			scan = SCAN_IDLE;
		end
	endtask

	task automatic lex_word(input src_word_t w);
		logic [31:0] here;
		logic [7:0] c;
		logic [3:0] kind;
		c = w.char_code;
		word_tokens = {};
		if (scan != SCAN_STOPPED) begin
			if (w.mode == SRC_END) begin
				flush_run();
				add_token(make_token(KIND_END, bytes_seen, 8'd0, line_no,
					bump_position(col_no)));
				scan = SCAN_STOPPED;
			end else begin
				here = bytes_seen;
				if (bytes_seen != 32'hFFFF_FFFF)
					bytes_seen = bytes_seen + 32'd1;
				if (c == CH_CR || c == CH_LF) begin
					line_no = bump_position(line_no);
					col_no = 16'd1;
				end else begin
					col_no = bump_position(col_no);
				end
				if ((scan == SCAN_NUMBER && is_digit_byte(c)) ||
					(scan == SCAN_IDENT && (is_digit_byte(c) || is_word_byte(c)))) begin
					if (run_len < RUN_LEN_CAP)
						run_len = run_len + 8'd1;
				end else begin
					flush_run();
					if (is_digit_byte(c) || is_word_byte(c)) begin
						scan = is_digit_byte(c) ? SCAN_NUMBER : SCAN_IDENT;
						run_offset = here;
						run_line = line_no;
						run_col = col_no;
						run_len = 8'd1;
					end else if (!is_blank(c)) begin
						kind = single_kind(c);
						add_token(make_token(kind, here, 8'd1, line_no, col_no));
						if (kind == KIND_INVALID)
							scan = SCAN_STOPPED;
					end
				end
			end
		end
		if (word_tokens.size() > 0)
			word_tokens[word_tokens.size() - 1].last_of_run = 1'b1;
		due_tokens = {due_tokens, word_tokens};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan = SCAN_IDLE;
			bytes_seen = 32'd0;
			line_no = 16'd1;
			col_no = 16'd0;
			run_offset = 32'd0;
			run_line = 16'd0;
			run_col = 16'd0;
			run_len = 8'd0;
			due_tokens = {};
			due_count = 0;
		end else begin
			if (tok_valid && !tok_stall) begin
				if (due_tokens.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: unexpected token kind %0d offset %0d length %0d",
							$time, tok_data.token_kind, tok_data.token_offset,
							tok_data.token_length);
					mismatch_count++;
				end else begin
					want = due_tokens.pop_front();
					checked_count++;
					if (tok_data.token_kind !== want.token_kind ||
						tok_data.token_offset !== want.token_offset ||
						tok_data.token_length !== want.token_length ||
						tok_data.start_line !== want.start_line ||
						tok_data.start_column !== want.start_column ||
						tok_data.last_of_run !== want.last_of_run) begin
						if (mismatch_count < 10) begin
							$display("%0t: token mismatch", $time);
							$display("  expected kind %0d off %0d len %0d line %0d col %0d last %0d",
								want.token_kind, want.token_offset, want.token_length,
								want.start_line, want.start_column, want.last_of_run);
							$display("  actual   kind %0d off %0d len %0d line %0d col %0d last %0d",
								tok_data.token_kind, tok_data.token_offset,
								tok_data.token_length, tok_data.start_line,
								tok_data.start_column, tok_data.last_of_run);
						end
						mismatch_count++;
					end
				end
			end
			if (src_valid && !src_stall)
				lex_word(src_data);
			due_count = due_tokens.size();
		end
	end

endmodule

// ===== dv/expression_token_lexer_tb.sv =====
`timescale 1ns / 1ps

module expression_token_lexer_tb;
	import etl_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic src_valid;
	logic src_stall;
	src_word_t src_data;
	logic tok_valid;
	logic tok_stall;
	tok_word_t tok_data;

	int errors;
	int outstanding;
	int tokens_checked;
	int words_sent = 0;
	int words_ignored = 0;
	int long_len = 0;
	bit src_steady = 1'b0;
	bit tok_steady = 1'b0;
	bit closed_by_end;

	always #5 clk = ~clk;

	expression_token_lexer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data(src_data),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_data(tok_data)
	);

	expression_token_lexer_checker lex_check (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data(src_data),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_data(tok_data),
		.errors(errors),
		.outstanding(outstanding),
		.tokens_checked(tokens_checked)
	);

	function automatic int wait_cycles(input bit steady);
		return steady ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic logic [7:0] digit_byte();
		return 8'(CH_0 + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] word_start_byte();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'(CH_LA + r);
		else if (r < 52)
			return 8'(CH_UA + r - 26);
		return CH_US;
	endfunction

	function automatic logic [7:0] word_byte();
		if ($urandom_range(0, 3) == 0)
			return digit_byte();
		return word_start_byte();
	endfunction

	function automatic logic [7:0] op_byte();
		logic [7:0] c;
		case ($urandom_range(0, 7))
			0: c = CH_EQ;
			1: c = CH_PLUS;
			2: c = CH_MINUS;
			3: c = CH_STAR;
			4: c = CH_SLASH;
			5: c = CH_SEMI;
			6: c = CH_LPAR;
			default: c = CH_RPAR;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] blank_byte();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0: c = CH_SP;
			1: c = CH_TAB;
			2: c = CH_CR;
			default: c = CH_LF;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] any_legal_byte();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0: c = digit_byte();
			1: c = word_start_byte();
			2: c = op_byte();
			default: c = blank_byte();
		endcase
		return c;
	endfunction

	function automatic logic [7:0] bad_byte();
		logic [7:0] c;
		case ($urandom_range(0, 5))
			0: c = 8'h00;
			1: c = 8'hFF;
			2: c = 8'h0B;
			3: c = 8'h0C;
			4: c = 8'h7F;
			default: c = 8'($urandom_range(128, 255));
		endcase
		return c;
	endfunction

	task automatic send_word(input logic mode, input logic [7:0] c);
		int gap;
		if ($urandom_range(0, 39) == 0)
			src_steady = !src_steady;
		gap = wait_cycles(src_steady);
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data <= {mode, c};
		@(posedge clk);
		while (src_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_run(input bit numeric, input int len);
		send_word(SRC_CHAR, numeric ? digit_byte() : word_start_byte());
		repeat (len - 1) send_word(SRC_CHAR, numeric ? digit_byte() : word_byte());
	endtask

	task automatic wait_tokens_drained();
		src_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// token sink with random stalls
	initial begin
		int gap;
		tok_stall = 1'b0;
		forever begin
			if ($urandom_range(0, 39) == 0)
				tok_steady = !tok_steady;
			gap = wait_cycles(tok_steady);
			if (gap > 0) begin
				tok_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			tok_stall <= 1'b0;
			@(posedge clk);
			while (!tok_valid) @(posedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d tokens outstanding", outstanding);
		$display("simulation failed");
		$finish;
	end

	initial begin
		string opening;
		int next_pause;
		int pick;
		bit long_done;
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every operator, run adjacency, crlf, blanks
		opening = "x1=(42+_b)*7q-9/Z;\t \r\n0";
		for (int i = 0; i < opening.len(); i++)
			send_word(SRC_CHAR, opening[i]);
		wait_tokens_drained();

		next_pause = 150;
		long_done = 1'b0;
		while (words_sent < 650) begin
			pick = $urandom_range(0, 99);
			if (!long_done && words_sent > 250) begin
				// run past the length limit
				long_len = $urandom_range(256, 290);
				send_run(1'($urandom_range(0, 1)), long_len);
				long_done = 1'b1;
			end else if (pick < 8) begin
				send_word(SRC_CHAR, any_legal_byte());
			end else if (pick < 30) begin
				send_run(1'b1, $urandom_range(1, 6));
			end else if (pick < 55) begin
				send_run(1'b0, $urandom_range(1, 9));
			end else if (pick < 80) begin
				send_word(SRC_CHAR, op_byte());
			end else begin
				repeat ($urandom_range(1, 3)) send_word(SRC_CHAR, blank_byte());
			end
			if (words_sent >= next_pause) begin
				wait_tokens_drained();
				next_pause += 150;
			end
		end

		// pending run, then stop the stream
		send_run(1'b0, $urandom_range(1, 4));
		closed_by_end = 1'($urandom_range(0, 1));
		if (closed_by_end)
			send_word(SRC_END, 8'($urandom_range(0, 255)));
		else
			send_word(SRC_CHAR, bad_byte());

		// words after the stop must be ignored
		for (int i = 0; i < 12; i++) begin
			send_word(1'($urandom_range(0, 1)),
				(i < 4) ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255)));
			words_ignored++;
		end

		wait_tokens_drained();
		repeat (20) @(posedge clk);

		$display("lexed %0d source words (%0d after the stop), %0d tokens checked",
			words_sent, words_ignored, tokens_checked);
		$display("stream closed by %s, longest run %0d bytes past the length limit",
			closed_by_end ? "end of input" : "an invalid byte", long_len);
		if (errors == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			if (outstanding != 0)
				$display("%0d tokens never arrived", outstanding);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/etl_pkg.sv
sv/etl_scan.sv
sv/etl_queue.sv
sv/expression_token_lexer.sv
dv/expression_token_lexer_checker.sv
dv/expression_token_lexer_tb.sv
